/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console character writer: shared types and constants
// Cell layout, command and character codes, register indexes, and the
// structs that pass between the sequencer, the screen store and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CELL_W  = 16;
  localparam int CIDX_W  = 14;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int COLS_W  = 8;
  localparam int LINES_W = 7;

  localparam logic [COLS_W-1:0]  COLS_MAX  = 8'd128;
  localparam logic [LINES_W-1:0] LINES_MAX = 7'd64;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CHAR_NULL    = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam logic [1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [1:0] CFG_LINES     = 2'd1;
  localparam logic [1:0] CFG_FILL_ATTR = 2'd2;

  localparam logic [COLS_W-1:0]  COLUMNS_RESET   = 8'd80;
  localparam logic [LINES_W-1:0] LINES_RESET     = 7'd25;
  localparam logic [7:0]         FILL_ATTR_RESET = 8'd7;

  localparam logic [1:0] BE_NONE = 2'b00;
  localparam logic [1:0] BE_CHAR = 2'b01;
  localparam logic [1:0] BE_CELL = 2'b11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [COLS_W-1:0]  cols;
    logic [LINES_W-1:0] lines;
    logic [7:0]         fill_attr;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [1:0]        be;
    logic [CIDX_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [CIDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             scrolled;
  } res_t;

endpackage

/* design/tcw_screen_mem.sv */
// ----------------------------------------------------------------------------
// Text console character writer: screen store
// Synchronous single-port-write, single-port-read memory of 16-bit cells with
// byte enables. Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
  parameter int DEPTH = 2048
) (
  input  logic                         clk,
  input  tcw_pkg::mem_req_t            req,
  output logic [tcw_pkg::CELL_W-1:0]   rdata
);
  import tcw_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      if (req.be[0]) begin
        cells[req.waddr[AW-1:0]][7:0] <= req.wdata[7:0];
      end
      if (req.be[1]) begin
        cells[req.waddr[AW-1:0]][15:8] <= req.wdata[15:8];
      end
    end
    rdata <= cells[req.raddr[AW-1:0]];
  end

endmodule

/* design/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// Text console character writer: sequencer
// Holds the cursor, breaks each item into cell writes, advances and newlines,
// runs the scroll copy and fill sweeps and the clearing pass over the store,
// and keeps the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int SCREEN_CELLS = 2048,
  parameter int TAB_SPACES   = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [7:0]                 char_code,
  input  logic [10:0]                read_address,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tcw_pkg::res_t              res,
  input  tcw_pkg::cfg_t              cfg,
  output tcw_pkg::mem_req_t          mem_req,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
  import tcw_pkg::*;

  localparam int AW = $clog2(SCREEN_CELLS);
  localparam int TW = $clog2(TAB_SPACES + 1);
  localparam logic [CIDX_W-1:0] SC_LIM   = CIDX_W'(SCREEN_CELLS);
  localparam logic [AW-1:0]     CLR_LAST = AW'(SCREEN_CELLS - 1);

  state_t state, state_next;

  logic [AW-1:0]     clr_idx;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [TW-1:0]     writes_left, writes_left_next;
  logic              adv_left, adv_left_next;
  logic              nl_pending, nl_pending_next;
  logic [7:0]        wr_char;
  logic              scroll_flag;
  logic [CIDX_W-1:0] scr_n, scr_idx;
  logic              pend_valid;
  logic [CIDX_W-1:0] pend_dst;
  logic [CELL_W-1:0] res_cell;
  logic              read_ok;

  logic              accept, in_step;
  logic              op_write, op_adv, op_nl;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              wrap, do_nl, scroll_start, remaining;
  logic              out_free, finish_req, finish;
  logic [CIDX_W-1:0] cur_addr, scr_n_calc, copy_src, fill_dst;
  logic              copy_active, fill_last;
  logic [CELL_W-1:0] out_cell;

  assign accept   = (state == ST_IDLE) && in_valid;
  assign in_step  = (state == ST_STEP);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    op_write = in_step && (writes_left != '0);
    op_adv   = in_step && (writes_left == '0) && adv_left;
    op_nl    = in_step && (writes_left == '0) && !adv_left && nl_pending;

    col_inc      = {1'b0, col} + (COL_W+1)'(1);
    row_inc      = {1'b0, row} + (ROW_W+1)'(1);
    wrap         = (op_write || op_adv) && (col_inc >= cfg.cols);
    do_nl        = op_nl || wrap;
    scroll_start = do_nl && (row_inc >= cfg.lines);

    if (do_nl) begin
      col_next = '0;
    end else if (op_write || op_adv) begin
      col_next = col_inc[COL_W-1:0];
    end else begin
      col_next = col;
    end

    if (scroll_start) begin
      row_next = ROW_W'(cfg.lines - 7'd1);
    end else if (do_nl) begin
      row_next = row_inc[ROW_W-1:0];
    end else begin
      row_next = row;
    end

    writes_left_next = op_write ? writes_left - TW'(1) : writes_left;
    adv_left_next    = op_adv ? 1'b0 : adv_left;
    nl_pending_next  = op_nl ? 1'b0 : nl_pending;
    remaining        = (writes_left_next != '0) || adv_left_next || nl_pending_next;

    cur_addr    = CIDX_W'(row) * CIDX_W'(cfg.cols) + CIDX_W'(col);
    scr_n_calc  = CIDX_W'(cfg.lines - 7'd1) * CIDX_W'(cfg.cols);
    copy_src    = scr_idx + CIDX_W'(cfg.cols);
    fill_dst    = scr_n + scr_idx;
    copy_active = scr_idx < scr_n;
    fill_last   = scr_idx == CIDX_W'(cfg.cols - 8'd1);

    finish_req = (state == ST_READ) || (state == ST_FINISH)
              || (in_step && !scroll_start && !remaining)
              || ((state == ST_FILL) && fill_last && !remaining);
    finish     = finish_req && out_free;

    out_cell = (state == ST_READ) ? (read_ok ? mem_rdata : '0) : res_cell;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (command == CMD_READ) ? ST_READ : ST_STEP;
      end
      ST_READ: begin
        state_next = finish ? ST_IDLE : ST_FINISH;
      end
      ST_STEP: begin
        if (scroll_start) begin
          state_next = ST_COPY;
        end else if (!remaining) begin
          state_next = finish ? ST_IDLE : ST_FINISH;
        end
      end
      ST_COPY: begin
        if (!copy_active) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (fill_last) begin
          if (remaining) begin
            state_next = ST_STEP;
          end else begin
            state_next = finish ? ST_IDLE : ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.be    = BE_NONE;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.raddr = CIDX_W'(read_address);
    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.be    = BE_CELL;
        mem_req.waddr = CIDX_W'(clr_idx);
      end
      ST_STEP: begin
        if (op_write && (cur_addr < SC_LIM)) begin
          mem_req.we    = 1'b1;
          mem_req.be    = BE_CHAR;
          mem_req.waddr = cur_addr;
          mem_req.wdata = {8'h00, wr_char};
        end
      end
      ST_COPY: begin
        mem_req.raddr = copy_src;
        if (pend_valid) begin
          mem_req.we    = 1'b1;
          mem_req.be    = BE_CELL;
          mem_req.waddr = pend_dst;
          mem_req.wdata = mem_rdata;
        end
      end
      ST_FILL: begin
        if (fill_dst < SC_LIM) begin
          mem_req.we    = 1'b1;
          mem_req.be    = BE_CELL;
          mem_req.waddr = fill_dst;
          mem_req.wdata = {cfg.fill_attr, CHAR_SPACE};
        end
      end
      ST_IDLE, ST_READ, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      col         <= '0;
      row         <= '0;
      writes_left <= '0;
      adv_left    <= 1'b0;
      nl_pending  <= 1'b0;
      scroll_flag <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_COPY) && copy_active && (copy_src < SC_LIM);

      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end

      if (accept) begin
        scroll_flag <= 1'b0;
        res_cell    <= '0;
        read_ok     <= CIDX_W'(read_address) < SC_LIM;
        if (command == CMD_PUT) begin
          case (char_code)
            CHAR_NEWLINE: nl_pending <= 1'b1;
            CHAR_TAB: begin
              writes_left <= TW'(TAB_SPACES);
              adv_left    <= 1'b1;
              wr_char     <= CHAR_SPACE;
            end
            CHAR_NULL: begin
            end
            default: begin
              writes_left <= TW'(1);
              wr_char     <= char_code;
            end
          endcase
        end
      end

      if (in_step) begin
        col         <= col_next;
        row         <= row_next;
        writes_left <= writes_left_next;
        adv_left    <= adv_left_next;
        nl_pending  <= nl_pending_next;
        if (scroll_start) begin
          scroll_flag <= 1'b1;
          scr_n       <= scr_n_calc;
          scr_idx     <= '0;
        end
      end

      if (state == ST_COPY) begin
        pend_dst <= scr_idx;
        scr_idx  <= copy_active ? scr_idx + CIDX_W'(1) : '0;
      end

      if (state == ST_FILL) begin
        scr_idx <= scr_idx + CIDX_W'(1);
      end

      if (state == ST_READ) begin
        res_cell <= out_cell;
      end

      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res.cell_char <= out_cell[7:0];
      res.cell_attr <= out_cell[15:8];
      res.col       <= col_next;
      res.row       <= row_next;
      res.scrolled  <= scroll_flag;
    end
  end

endmodule

/* design/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// Text console character writer
// Text-mode console engine: cursor, screen store of character and attribute
// cells, put and read commands, line wrap, newline, tab and scrolling.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Contents
//  in       in_valid / in_stall    command, char_code, read_address
//  out      out_valid / out_stall  cell_char, cell_attribute, cursor_column,
//                                  cursor_row, scrolled
//  cfg      cfg_write              cfg_index, cfg_data (columns, lines, fill)
//
// A tab makes TAB_SPACES cell writes of a space and then one final advance.
// Each scroll copies the lower rows up one and fills the last row, one store
// cell a cycle through the single read and write port of the screen store.
// After reset a clearing pass zeroes every cell of the store, during which
// in_stall is high; configuration writes are taken throughout.
// A result waiting under out_stall holds back only the next item's completion.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int SCREEN_CELLS = 2048,
  parameter int TAB_SPACES   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  char_code,
  input  logic [10:0] read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attribute,
  output logic [6:0]  cursor_column,
  output logic [5:0]  cursor_row,
  output logic        scrolled,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  logic [COLS_W-1:0]  columns;
  logic [LINES_W-1:0] lines;
  logic [7:0]         fill_attribute;
  cfg_t               cfg;
  res_t               res;
  mem_req_t           mem_req;
  logic [CELL_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns        <= COLUMNS_RESET;
      lines          <= LINES_RESET;
      fill_attribute <= FILL_ATTR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLUMNS:   columns        <= cfg_data;
        CFG_LINES:     lines          <= cfg_data[LINES_W-1:0];
        CFG_FILL_ATTR: fill_attribute <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (columns == '0) begin
      cfg.cols = COLS_W'(1);
    end else if (columns > COLS_MAX) begin
      cfg.cols = COLS_MAX;
    end else begin
      cfg.cols = columns;
    end

    if (lines == '0) begin
      cfg.lines = LINES_W'(1);
    end else if (lines > LINES_MAX) begin
      cfg.lines = LINES_MAX;
    end else begin
      cfg.lines = lines;
    end

    cfg.fill_attr = fill_attribute;
  end

  tcw_screen_mem #(
    .DEPTH (SCREEN_CELLS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  tcw_ctrl #(
    .SCREEN_CELLS (SCREEN_CELLS),
    .TAB_SPACES   (TAB_SPACES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .char_code    (char_code),
    .read_address (read_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res          (res),
    .cfg          (cfg),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  assign cell_char      = res.cell_char;
  assign cell_attribute = res.cell_attr;
  assign cursor_column  = res.col;
  assign cursor_row     = res.row;
  assign scrolled       = res.scrolled;

endmodule

/* bench/tb_text_console_char_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the text console character writer
// Feeds put and read commands through the input channel in random bursts,
// while the result channel stalls on its own changing pattern. A behavioural
// screen, cursor and register copy held here predicts every result, and each
// result is checked field by field in order. The run moves through several
// screen geometries, including zero, saturated and maximum sizes, shrinking
// the screen under the cursor and long scrolls.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam int unsigned STORE_CELLS    = 2048;
  localparam int unsigned TAB_RUN        = 5;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] read_address;
    bit          drain_first;
  } console_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_PUT;
  logic [7:0]  char_code = CHAR_NULL;
  logic [10:0] read_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attribute;
  logic [6:0]  cursor_column;
  logic [5:0]  cursor_row;
  logic        scrolled;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_COLUMNS;
  logic [7:0]  cfg_data = '0;

  console_item_t pending_items[$];
  res_t          expected_results[$];

  logic [15:0]  screen_model [0:STORE_CELLS-1];
  int unsigned  model_col;
  int unsigned  model_row;
  logic [7:0]   model_cols;
  logic [6:0]   model_lines;
  logic [7:0]   model_fill;
  bit           model_scrolled;

  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;

  console_item_t live_item;
  console_item_t next_item;
  res_t          predicted;
  res_t          wanted;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  int unsigned   stall_mode = 0;
  int unsigned   stall_mode_left = 0;
  int unsigned   stall_tick = 0;
  logic          stall_next;

  text_console_char_writer #(
    .SCREEN_CELLS(STORE_CELLS),
    .TAB_SPACES(TAB_RUN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .char_code(char_code),
    .read_address(read_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_char(cell_char),
    .cell_attribute(cell_attribute),
    .cursor_column(cursor_column),
    .cursor_row(cursor_row),
    .scrolled(scrolled),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_cols();
    if (model_cols == 0) return 1;
    if (model_cols > COLS_MAX) return COLS_MAX;
    return model_cols;
  endfunction

  function automatic int unsigned eff_lines();
    if (model_lines == 0) return 1;
    if (model_lines > LINES_MAX) return LINES_MAX;
    return model_lines;
  endfunction

  task automatic next_line();
    int unsigned cols;
    int unsigned shifted;
    logic [15:0] blank;
    cols = eff_cols();
    model_col = 0;
    model_row++;
    if (model_row >= eff_lines()) begin
      shifted = (eff_lines() - 1) * cols;
      blank = {model_fill, CHAR_SPACE};
      for (int unsigned i = 0; i < shifted; i++) begin
        if (i + cols < STORE_CELLS) screen_model[i] = screen_model[i + cols];
      end
      for (int unsigned i = 0; i < cols; i++) begin
        if (shifted + i < STORE_CELLS) screen_model[shifted + i] = blank;
      end
      model_scrolled = 1'b1;
      model_row = eff_lines() - 1;
    end
  endtask

  task automatic move_right();
    model_col++;
    if (model_col >= eff_cols()) next_line();
  endtask

  task automatic put_cell(input logic [7:0] ch);
    int unsigned addr;
    addr = model_row * eff_cols() + model_col;
    if (addr < STORE_CELLS) screen_model[addr][7:0] = ch;
    move_right();
  endtask

  task automatic predict_step(input console_item_t it, output res_t r);
    logic [15:0] read_cell;
    read_cell = '0;
    model_scrolled = 1'b0;
    if (it.command == CMD_READ) begin
      read_cell = screen_model[it.read_address];
    end else if (it.char_code == CHAR_NEWLINE) begin
      next_line();
    end else if (it.char_code == CHAR_TAB) begin
      repeat (TAB_RUN) put_cell(CHAR_SPACE);
      move_right();
    end else if (it.char_code != CHAR_NULL) begin
      put_cell(it.char_code);
    end
    r.cell_char = read_cell[7:0];
    r.cell_attr = read_cell[15:8];
    r.col       = model_col[COL_W-1:0];
    r.row       = model_row[ROW_W-1:0];
    r.scrolled  = model_scrolled;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_step(live_item, predicted);
        expected_results.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain_first && expected_results.size() != 0)) begin
          next_item = pending_items.pop_front();
          live_item <= next_item;
          command <= next_item.command;
          char_code <= next_item.char_code;
          read_address <= next_item.read_address;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on a pattern that changes mode.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", cursor_column, 0);
        end else begin
          wanted = expected_results.pop_front();
          if (cell_char !== wanted.cell_char)
            report_mismatch("cell_char", cell_char, wanted.cell_char);
          if (cell_attribute !== wanted.cell_attr)
            report_mismatch("cell_attribute", cell_attribute, wanted.cell_attr);
          if (cursor_column !== wanted.col)
            report_mismatch("cursor_column", cursor_column, wanted.col);
          if (cursor_row !== wanted.row)
            report_mismatch("cursor_row", cursor_row, wanted.row);
          if (scrolled !== wanted.scrolled)
            report_mismatch("scrolled", scrolled, wanted.scrolled);
        end
      end
      stall_tick++;
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(20, 200);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ((stall_tick % 5) < 2);
      endcase
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_text_console_char_writer NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      CFG_COLUMNS:   model_cols = value;
      CFG_LINES:     model_lines = value[6:0];
      CFG_FILL_ATTR: model_fill = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] cols, input logic [7:0] lines,
                           input logic [7:0] fill);
    write_register(CFG_COLUMNS, cols);
    write_register(CFG_LINES, lines);
    write_register(CFG_FILL_ATTR, fill);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_put(input logic [7:0] ch, input bit drain = 1'b0);
    console_item_t it;
    it.command = CMD_PUT;
    it.char_code = ch;
    it.read_address = 11'($urandom_range(0, STORE_CELLS - 1));
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  task automatic add_read(input logic [10:0] addr, input logic [7:0] ch, input bit drain = 1'b0);
    console_item_t it;
    it.command = CMD_READ;
    it.char_code = ch;
    it.read_address = addr;
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  function automatic logic [7:0] one_of(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic console_item_t random_item(input int unsigned span);
    console_item_t it;
    int unsigned pick;
    it.drain_first = ($urandom_range(0, 59) == 0);
    if ($urandom_range(0, 3) == 0 || span == 0)
      it.read_address = 11'($urandom_range(0, STORE_CELLS - 1));
    else
      it.read_address =
        11'($urandom_range(0, (span > STORE_CELLS ? STORE_CELLS : span) - 1));
    it.command = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_PUT;
    pick = $urandom_range(0, 99);
    if (pick < 10)      it.char_code = CHAR_NEWLINE;
    else if (pick < 17) it.char_code = CHAR_TAB;
    else if (pick < 20) it.char_code = CHAR_NULL;
    else if (pick < 55) it.char_code = 8'($urandom_range(8'h20, 8'h7E));
    else                it.char_code = 8'($urandom_range(0, 255));
    return it;
  endfunction

  initial begin : stimulus
    int unsigned random_count;
    int unsigned span;
    int unsigned phase_items;
    int unsigned sel;
    logic [7:0]  cols;
    logic [7:0]  lines;
    logic [7:0]  fill;

    foreach (screen_model[i]) screen_model[i] = '0;
    model_col = 0;
    model_row = 0;
    model_cols = COLUMNS_RESET;
    model_lines = LINES_RESET;
    model_fill = FILL_ATTR_RESET;
    random_count = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Small screen: wrap, tab across a line end, newline scroll, reads.
    configure(8'd4, 8'd3, 8'hA5);
    add_read(11'd0, 8'hFF);
    add_read(11'd2047, CHAR_NULL);
    add_put(8'h41);
    add_put(8'hFF);
    add_put(8'h80);
    add_put(CHAR_NULL);
    add_put(CHAR_TAB);
    add_put(CHAR_NEWLINE);
    add_put(CHAR_NEWLINE);
    add_put(8'h7F);
    add_put(8'h01);
    repeat (5) add_put(8'h5A);
    add_read(11'd0, CHAR_TAB);
    add_read(11'd5, CHAR_NEWLINE);
    add_read(11'd11, 8'h00);
    add_read(11'd12, 8'h41);
    add_put(CHAR_TAB, 1'b1);
    wait_until_idle();

    // Zero sizes behave as one column and one line.
    configure(8'd0, 8'd0, 8'hFF);
    add_put(8'h61);
    add_put(CHAR_TAB);
    add_put(CHAR_NEWLINE);
    add_read(11'd0, 8'h55, 1'b1);
    wait_until_idle();

    // Oversized registers saturate; rows far down lie beyond the store.
    configure(8'd255, 8'd127, 8'h00);
    add_put(8'h62);
    repeat (66) add_put(CHAR_NEWLINE);
    add_put(8'h63);
    add_put(CHAR_TAB);
    add_read(11'd2047, CHAR_NULL);
    wait_until_idle();

    // Shrink the screen under the cursor.
    configure(8'd3, 8'd2, 8'h3C);
    add_put(8'h64);
    add_put(8'h65);
    add_read(11'd0, CHAR_NULL);
    wait_until_idle();

    configure(COLS_MAX, {1'b0, LINES_MAX}, 8'h81);
    add_put(CHAR_NEWLINE);
    add_put(8'h66);
    add_read(11'd128, CHAR_NULL);
    wait_until_idle();

    while (random_count < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        cols = one_of(8'd0, 8'd1, 8'd128, 8'd255);
        lines = one_of(8'd0, 8'd1, 8'd64, 8'd127);
        fill = one_of(8'h00, 8'hFF, 8'h00, 8'hFF);
      end else if (sel == 1) begin
        cols = 8'($urandom_range(40, 128));
        lines = 8'($urandom_range(10, 64));
        fill = 8'($urandom_range(0, 255));
      end else begin
        cols = 8'($urandom_range(1, 16));
        lines = 8'($urandom_range(1, 8));
        fill = 8'($urandom_range(0, 255));
      end
      configure(cols, lines, fill);
      span = eff_cols() * eff_lines();
      phase_items = (span > 512) ? 25 : $urandom_range(60, 140);
      repeat (phase_items) pending_items.push_back(random_item(span));
      random_count += phase_items;
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_text_console_char_writer OK");
    end else begin
      $display("tb_text_console_char_writer NOT OK");
    end
    $finish;
  end

endmodule
